### rtl/core/sosc_pkg.sv
// sosc_pkg: shared types, constants and sine table builder for the oscillator
`default_nettype none

package sosc_pkg;

  // field widths fixed by the stream format
  localparam int FREQ_W   = 24;
  localparam int PERIOD_W = 40;
  localparam int FRAC_W   = 16;

  // period multiply is cut into two halves of this width
  localparam int PERIOD_SPLIT = 20;
  localparam int PART_W       = FREQ_W + PERIOD_SPLIT;
  localparam int PROD_W       = 64;
  // freq (Q16.8) times period (2^-48 s) carries 56 fraction bits
  localparam int PROD_MSB     = 55;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 40'd5864062014;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);

  // fixed-point constants for the table builder
  localparam logic [63:0] Q30_ONE    = 64'd1 << 30;
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

  typedef logic [FREQ_W-1:0]   freq_t;
  typedef logic [PERIOD_W-1:0] period_t;

  // sin(2*pi*u), u a q32 fraction in [0, 1/4], result q30, taylor to x^13
  function automatic logic [63:0] quarter_sine(input logic [63:0] u);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] h;
    logic [63:0] v;
    logic [63:0] t;
    x  = (u * TWO_PI_Q30) >> 32;
    x2 = (x * x) >> 30;
    h  = Q30_ONE;
    for (int k = 0; k < 6; k++) begin
      v = (x2 * h) >> 30;
      case (k)
        0: t = v / 156;
        1: t = v / 110;
        2: t = v / 72;
        3: t = v / 42;
        4: t = v / 20;
        default: t = v / 6;
      endcase
      h = (t >= Q30_ONE) ? 64'd0 : Q30_ONE - t;
    end
    return (x * h) >> 30;
  endfunction

  // table entry i of a 2^aw entry table, sb-bit signed, returned in 24 bits
  function automatic logic [23:0] rom_value(input int unsigned idx,
                                            input int unsigned aw,
                                            input int unsigned sb);
    logic [63:0] t;
    logic [63:0] amp;
    logic [63:0] s;
    logic [63:0] mag;
    logic        neg;
    t   = 64'(idx) << (32 - aw);
    amp = (64'd1 << (sb - 1)) - 64'd1;
    neg = 1'b0;
    if (t >= (64'd1 << 31)) begin
      neg = 1'b1;
      t   = t - (64'd1 << 31);
    end
    if (t > (64'd1 << 30)) begin
      t = (64'd1 << 31) - t;
    end
    s   = quarter_sine(t);
    mag = (s * amp + (64'd1 << 29)) >> 30;
    if (mag > amp) begin
      mag = amp;
    end
    return neg ? 24'(-mag) : 24'(mag);
  endfunction

endpackage

`default_nettype wire

### rtl/core/sosc_front.sv
// sosc_front: takes frames, holds the period register, forms the phase step
`default_nettype none

module sosc_front #(
  parameter int PHASE_BITS = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire sosc_pkg::freq_t                 in_freq,
  input  wire logic                            in_mark,
  input  wire logic                            cfg_wr_en,
  input  wire sosc_pkg::period_t               cfg_wr_data,
  input  wire logic [sosc_pkg::LEVEL_W-1:0]    q_level,
  output logic                                 push,
  output logic [PHASE_BITS-1:0]                push_inc,
  output logic                                 push_mark
);

  sosc_pkg::period_t                  sample_period;
  logic                               f1_valid;
  logic                               f1_mark;
  logic [sosc_pkg::PART_W-1:0]        part_lo;
  logic [sosc_pkg::PART_W-1:0]        part_hi;
  logic [sosc_pkg::PROD_W-1:0]        prod;
  logic                               accept;

  // period register
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_period <= sosc_pkg::PERIOD_RESET;
    end else if (cfg_wr_en) begin
      sample_period <= cfg_wr_data;
    end
  end

  // credit check: queue entries plus the one in the multiply stage
  assign in_ready = ({1'b0, q_level} + {{sosc_pkg::LEVEL_W{1'b0}}, f1_valid})
                    < (sosc_pkg::LEVEL_W + 1)'(sosc_pkg::QUEUE_DEPTH);
  assign accept   = in_valid && in_ready;

  // split multiply, partial products registered
  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else begin
      f1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      part_lo <= sosc_pkg::PART_W'(in_freq)
               * sosc_pkg::PART_W'(sample_period[sosc_pkg::PERIOD_SPLIT-1:0]);
      part_hi <= sosc_pkg::PART_W'(in_freq)
               * sosc_pkg::PART_W'(sample_period[sosc_pkg::PERIOD_W-1:sosc_pkg::PERIOD_SPLIT]);
      f1_mark <= in_mark;
    end
  end

  // combine halves and keep the phase step bits
  assign prod      = sosc_pkg::PROD_W'(part_lo)
                   + {part_hi, {sosc_pkg::PERIOD_SPLIT{1'b0}}};
  assign push      = f1_valid;
  assign push_inc  = prod[sosc_pkg::PROD_MSB -: PHASE_BITS];
  assign push_mark = f1_mark;

endmodule

`default_nettype wire

### rtl/core/sosc_queue.sv
// sosc_queue: small register queue between the front and the back
`default_nettype none

module sosc_queue #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 33
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  input  wire logic [WIDTH-1:0]           push_data,
  input  wire logic                       pop,
  output logic                            head_valid,
  output logic [WIDTH-1:0]                head_data,
  output logic [$clog2(DEPTH+1)-1:0]      level
);

  localparam int PTR_W = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             do_pop;

  assign head_valid = (level != '0);
  assign head_data  = mem[rd_ptr];
  assign do_pop     = pop && head_valid;

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      case ({push, do_pop})
        2'b10:   level <= level + ($clog2(DEPTH+1))'(1);
        2'b01:   level <= level - ($clog2(DEPTH+1))'(1);
        default: level <= level;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/sosc_back.sv
// sosc_back: phase accumulator, sine table read, interpolation, output register
`default_nettype none

module sosc_back #(
  parameter int PHASE_BITS  = 32,
  parameter int TABLE_SIZE  = 2048,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          q_valid,
  output logic                               q_pop,
  input  wire logic [PHASE_BITS-1:0]         q_inc,
  input  wire logic                          q_mark,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [SAMPLE_BITS-1:0]             out_sample,
  output logic                               out_mark
);

  localparam int ADDR_W = $clog2(TABLE_SIZE);
  localparam int FW     = sosc_pkg::FRAC_W;
  localparam int PROD_W = SAMPLE_BITS + FW + 2;
  localparam int SUM_W  = PROD_W + 1;

  logic [SAMPLE_BITS-1:0]        rom_tbl [TABLE_SIZE];
  logic [PHASE_BITS-1:0]         phase_acc;
  logic [ADDR_W-1:0]             idx;
  logic [ADDR_W-1:0]             nxt;
  logic [PHASE_BITS+FW-1:0]      frac_ext;
  logic [FW-1:0]                 frac;
  logic                          adv;

  logic                          v1;
  logic signed [SAMPLE_BITS-1:0] a1;
  logic signed [SAMPLE_BITS-1:0] b1;
  logic [FW-1:0]                 f1;
  logic                          m1;
  logic [FW:0]                   wa;

  logic                          v2;
  logic signed [PROD_W-1:0]      pa;
  logic signed [PROD_W-1:0]      pb;
  logic                          m2;
  logic signed [SUM_W-1:0]       sum;

  // sine table built at elaboration
  for (genvar i = 0; i < TABLE_SIZE; i++) begin : g_rom
    localparam logic [23:0] V = sosc_pkg::rom_value(i, ADDR_W, SAMPLE_BITS);
    assign rom_tbl[i] = V[SAMPLE_BITS-1:0];
  end

  // whole pipeline moves when the output register can take a word
  assign adv   = !out_valid || out_ready;
  assign q_pop = adv && q_valid;

  // table address and interpolation fraction from the current phase
  assign idx      = phase_acc[PHASE_BITS-1 -: ADDR_W];
  assign nxt      = idx + ADDR_W'(1);
  assign frac_ext = {phase_acc, {FW{1'b0}}} << ADDR_W;
  assign frac     = frac_ext[PHASE_BITS+FW-1 -: FW];

  // stage 1: phase update and registered table read
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc <= '0;
      v1        <= 1'b0;
    end else if (adv) begin
      v1 <= q_valid;
      if (q_valid) begin
        phase_acc <= phase_acc + q_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a1 <= rom_tbl[idx];
      b1 <= rom_tbl[nxt];
      f1 <= frac;
      m1 <= q_mark;
    end
  end

  // stage 2: weighted products
  assign wa = (FW + 1)'(1 << FW) - {1'b0, f1};

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pa <= PROD_W'(a1) * PROD_W'($signed({1'b0, wa}));
      pb <= PROD_W'(b1) * PROD_W'($signed({2'b00, f1}));
      m2 <= m1;
    end
  end

  // stage 3: round and register the result
  assign sum = SUM_W'(pa) + SUM_W'(pb) + SUM_W'(1 << (FW - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v2) begin
      out_sample <= sum[FW +: SAMPLE_BITS];
      out_mark   <= m2;
    end
  end

endmodule

`default_nettype wire

### rtl/core/sine_wavetable_oscillator.sv
// sine_wavetable_oscillator: top level of the sine wavetable oscillator
// Usage:
//  - s_* channel: one transaction per audio frame; s_tdata[23:0] is the
//    frequency in Hz (unsigned Q16.8), s_tlast marks the last frame of a block.
//  - m_* channel: one transaction per frame; m_tdata holds the signed sample
//    (Q1.15 at the default width), m_tlast is the copied block mark.
//  - cfg_wr_en/cfg_wr_data write the sample period (seconds times 2^48);
//    write it only while no frames are in flight.
//  - throughput: one frame per cycle while m_tready is high, set by the single
//    phase add in the back pipeline; the table read is one stage and the
//    interpolation two.
//  - input to output valid: the split period multiply is captured at the
//    accepting edge, then queue write, table read, products, rounding register.
//  - reset clears the phase to zero, the period to 1/48000 s and empties the
//    pipeline; the sine table is constant and needs no fill.
//  - when m_tready is low the back pipeline holds, the 4-entry queue fills and
//    s_tready drops once queue plus multiply stage are full.
`default_nettype none

module sine_wavetable_oscillator #(
  parameter int PHASE_BITS  = 32,
  parameter int TABLE_SIZE  = 2048,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // frequency (24 bits)
  input  wire logic [sosc_pkg::FREQ_W-1:0]         s_tdata,
  input  wire logic                                s_tlast,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // sample (SAMPLE_BITS bits), zero filled to whole bytes
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]         m_tdata,
  output logic                                     m_tlast,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  input  wire logic                                cfg_wr_en,
  input  wire logic [sosc_pkg::PERIOD_W-1:0]       cfg_wr_data
);

  localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int Q_W     = PHASE_BITS + 1;

  logic                            q_push;
  logic [PHASE_BITS-1:0]           push_inc;
  logic                            push_mark;
  logic                            q_pop;
  logic                            q_valid;
  logic [Q_W-1:0]                  q_head;
  logic [sosc_pkg::LEVEL_W-1:0]    q_level;
  logic [SAMPLE_BITS-1:0]          out_sample;

  // front: accept and phase step
  sosc_front #(
    .PHASE_BITS (PHASE_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_freq     (s_tdata),
    .in_mark     (s_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_level     (q_level),
    .push        (q_push),
    .push_inc    (push_inc),
    .push_mark   (push_mark)
  );

  // queue of {mark, step}
  sosc_queue #(
    .DEPTH (sosc_pkg::QUEUE_DEPTH),
    .WIDTH (Q_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  ({push_mark, push_inc}),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_head),
    .level      (q_level)
  );

  // back: phase, table, interpolation
  sosc_back #(
    .PHASE_BITS  (PHASE_BITS),
    .TABLE_SIZE  (TABLE_SIZE),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_inc      (q_head[PHASE_BITS-1:0]),
    .q_mark     (q_head[PHASE_BITS]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_sample (out_sample),
    .out_mark   (m_tlast)
  );

  assign m_tdata = TDATA_W'(out_sample);

  // queue never written when full unless it also drains
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_push && !q_pop && q_level == sosc_pkg::LEVEL_W'(sosc_pkg::QUEUE_DEPTH)))
    else $error("queue overflow");

  // fill level stays within the queue depth
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    q_level <= sosc_pkg::LEVEL_W'(sosc_pkg::QUEUE_DEPTH))
    else $error("queue level out of range");

  // no output straight after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

`default_nettype wire

### tb/sv/sine_wavetable_oscillator_test.sv
// sine_wavetable_oscillator_test: self-checking stream testbench for the sine oscillator
`timescale 1ns / 100ps

module sine_wavetable_oscillator_test;

  localparam int             FRAME_LIMIT_CYCLES = 200000;
  localparam int             DRAIN_CYCLES       = 8;
  localparam int             SETTLE_CYCLES      = 16;
  localparam int             MAX_PRINTED        = 20;
  localparam logic [39:0]    RESET_PERIOD       = 40'd5864062014;
  localparam logic [39:0]    MAX_PERIOD         = 40'hFF_FFFF_FFFF;
  localparam logic [23:0]    MAX_FREQ           = 24'hFF_FFFF;
  localparam longint unsigned Q30               = 64'd1 << 30;
  localparam longint unsigned TWO_PI_Q30        = 64'd6746518852;
  localparam longint unsigned FULL_SCALE        = 64'd32767;

  typedef struct packed {
    sosc_pkg::freq_t freq;
    logic            block_end;
  } osc_frame_t;

  typedef struct packed {
    logic signed [15:0] value;
    logic               block_end;
  } osc_sample_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  sosc_pkg::freq_t         s_tdata = '0;
  logic                    s_tlast = 1'b0;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [15:0]             m_tdata;
  logic                    m_tlast;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic                    cfg_wr_en = 1'b0;
  sosc_pkg::period_t       cfg_wr_data = '0;

  // one period of the sine, built from a folded taylor series
  logic signed [15:0]      sine_tab [2048];
  logic [31:0]             phase_model;
  sosc_pkg::period_t       period_model;

  osc_frame_t              frames_to_send [$];
  osc_sample_t             samples_due [$];
  logic                    in_taken = 1'b0;
  int                      send_idle_pct;
  int                      recv_idle_pct;
  int                      mismatches = 0;
  int                      samples_checked = 0;
  int                      frames_queued = 0;
  int                      marks_queued = 0;
  int                      settings_used = 1;
  int                      cycle_count = 0;

  sine_wavetable_oscillator DUT (
    .clk        (clk),
    .rst        (rst),
    .s_tdata    (s_tdata),     // [23:0] frequency
    .s_tlast    (s_tlast),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .m_tdata    (m_tdata),     // [15:0] sample
    .m_tlast    (m_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  // table entry i of 2048: quadrant fold, then q30 taylor series to x^13
  function automatic logic signed [15:0] sine_entry(input int unsigned i);
    longint unsigned u, x, x2, h, t, s, mag, dv;
    logic            below_axis;
    u = 64'(i) << 21;
    below_axis = (u >= (64'd1 << 31));
    if (below_axis) u = u - (64'd1 << 31);
    if (u > (64'd1 << 30)) u = (64'd1 << 31) - u;
    x  = (u * TWO_PI_Q30) >> 32;
    x2 = (x * x) >> 30;
    h  = Q30;
    for (int n = 6; n >= 1; n--) begin
      dv = 64'((2 * n) * (2 * n + 1));
      t  = ((x2 * h) >> 30) / dv;
      h  = (t >= Q30) ? 64'd0 : Q30 - t;
    end
    s   = (x * h) >> 30;
    mag = (s * FULL_SCALE + (64'd1 << 29)) >> 30;
    if (mag > FULL_SCALE) mag = FULL_SCALE;
    return below_axis ? -16'(mag) : 16'(mag);
  endfunction

  // linear interpolation between the addressed entry and the next, rounded
  function automatic logic signed [15:0] interpolated_sine(input logic [31:0] ph);
    logic [10:0] idx;
    longint      frac, a, b, acc;
    idx  = ph[31:21];
    frac = longint'(ph[20:5]);
    a    = sine_tab[idx];
    b    = sine_tab[idx + 11'd1];
    acc  = a * (65536 - frac) + b * frac + 32768;
    return 16'(acc >>> 16);
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("mismatch at sample %0d: %s got %0d expected %0d",
               samples_checked, what, got, want);
  endtask

  task automatic push_frame(input sosc_pkg::freq_t freq, input logic block_end);
    osc_frame_t fr;
    fr.freq      = freq;
    fr.block_end = block_end;
    frames_to_send.push_back(fr);
    frames_queued++;
    if (block_end) marks_queued++;
  endtask

  // mix of full-range steps, audio-band tones, sub-hertz tones and the extremes
  task automatic queue_random_frames(input int count);
    sosc_pkg::freq_t freq;
    int              pick;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      if (pick < 45)      freq = 24'($urandom_range(0, 24'hFF_FFFF));
      else if (pick < 75) freq = 24'($urandom_range(0, 20000 * 256));
      else if (pick < 88) freq = 24'($urandom_range(0, 255));
      else if (pick < 94) freq = 24'd0;
      else                freq = MAX_FREQ;
      push_frame(freq, $urandom_range(7) == 0);
    end
  endtask

  // drain, let the pipeline settle, write the period, then queue frames
  task automatic retune(input sosc_pkg::period_t period, input int count);
    while (frames_to_send.size() != 0 || s_tvalid || samples_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= period;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    settings_used++;
    queue_random_frames(count);
  endtask

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == FRAME_LIMIT_CYCLES) begin
      $display("timeout with %0d samples outstanding", samples_due.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // input driver: next frame after each accepted transaction, random gaps
  always @(negedge clk) begin
    osc_frame_t fr;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (frames_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        fr = frames_to_send.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= fr.freq;
        s_tlast  <= fr.block_end;
      end else begin
        s_tvalid <= 1'b0;
        s_tdata  <= 24'($urandom);
        s_tlast  <= 1'($urandom);
      end
    end
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // phase model on accepted frames, sample check on accepted outputs
  always @(posedge clk) begin
    osc_sample_t due;
    if (rst) begin
      phase_model  = '0;
      period_model = RESET_PERIOD;
      in_taken    <= 1'b0;
    end else begin
      if (cfg_wr_en) period_model = cfg_wr_data;
      in_taken <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        due.value     = interpolated_sine(phase_model);
        due.block_end = s_tlast;
        samples_due.push_back(due);
        phase_model = phase_model + 32'((64'(s_tdata) * 64'(period_model)) >> 24);
      end
      if (m_tvalid && m_tready) begin
        if (samples_due.size() == 0) begin
          report_mismatch("sample with none outstanding", longint'($signed(m_tdata)), 0);
        end else begin
          due = samples_due.pop_front();
          if ($signed(m_tdata) !== due.value)
            report_mismatch("sample", longint'($signed(m_tdata)), longint'(due.value));
          if (m_tlast !== due.block_end)
            report_mismatch("block end", longint'(m_tlast), longint'(due.block_end));
        end
        samples_checked++;
      end
    end
  end

  initial begin
    for (int i = 0; i < 2048; i++) sine_tab[i] = sine_entry(i);
    send_idle_pct = 37;
    recv_idle_pct = 68;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed frames at the reset period: hold at zero, extremes, wrapping steps
    push_frame(24'd0, 1'b0);
    push_frame(24'd0, 1'b1);
    push_frame(24'd0, 1'b0);
    push_frame(24'd1, 1'b0);
    push_frame(24'd440 << 8, 1'b0);
    push_frame(24'd440 << 8, 1'b0);
    push_frame(24'd440 << 8, 1'b1);
    push_frame(24'd0, 1'b0);
    push_frame(24'd0, 1'b0);
    push_frame(24'h80_0000, 1'b0);
    push_frame(24'h7F_FFFF, 1'b1);
    push_frame(MAX_FREQ, 1'b0);
    push_frame(MAX_FREQ, 1'b0);
    push_frame(MAX_FREQ, 1'b1);
    push_frame(24'd24000 << 8, 1'b0);
    push_frame(24'd12000 << 8, 1'b0);
    push_frame(24'd1000 << 8, 1'b0);
    push_frame(24'd1000 << 8, 1'b1);
    push_frame(24'hAA_AAAA, 1'b0);
    push_frame(24'h55_5555, 1'b1);

    // sender gaps light, receiver stalls heavy
    retune(RESET_PERIOD, 250);
    retune(40'd0, 60);
    retune(MAX_PERIOD, 150);

    // sender gaps heavy, receiver stalls light
    send_idle_pct = 68;
    recv_idle_pct = 37;
    retune(40'($urandom) | (40'($urandom_range(255)) << 32), 200);
    retune(40'd1, 60);
    retune(40'd6382661083, 150);

    // back to back in both directions
    send_idle_pct = 0;
    recv_idle_pct = 0;
    retune(40'($urandom) | (40'($urandom_range(255)) << 32), 200);
    retune(40'd0, 40);
    retune(MAX_PERIOD, 100);
    retune(RESET_PERIOD, 200);

    while (frames_to_send.size() != 0 || s_tvalid || samples_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("sent %0d frames (%0d block marks) over %0d period settings and three stall mixes",
             frames_queued, marks_queued, settings_used);
    $display("checked %0d samples, %0d mismatches", samples_checked, mismatches);
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
